/* design/greedy_activity_selection_assert.svh */
`ifndef GREEDY_ACTIVITY_SELECTION_ASSERT_SVH
`define GREEDY_ACTIVITY_SELECTION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/gas_pkg.sv */
package gas_pkg;

   localparam int MAX_ACTIVITIES = 64;
   localparam int TIME_BITS      = 16;
   localparam int COUNT_BITS     = 7;

   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] finish_time;
      logic                 last_item;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] selection_number;
      logic [TIME_BITS-1:0]  chosen_start;
      logic [TIME_BITS-1:0]  chosen_finish;
      logic                  last_of_run;
   } rsp_type;

   // one stored activity in the sorting chain
   typedef struct packed {
      logic                 valid;
      logic [TIME_BITS-1:0] start;
      logic [TIME_BITS-1:0] finish;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

endpackage

/* design/gas_cell.sv */
module gas_cell
   import gas_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  logic          left_greater,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          greater
);

   entry_type entry_ff;
   entry_type entry_in;

   // empty cells count as later than any new activity, ties stay ahead
   assign greater = !entry_ff.valid || (entry_ff.finish > new_entry.finish);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.shift) begin
         entry_in = right_entry;
      end else if (ctrl.insert && greater) begin
         entry_in = left_greater ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

/* design/gas_select.sv */
module gas_select
   import gas_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      run_begin,
   input  logic      take,
   input  logic      run_end,
   input  entry_type head,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   logic [TIME_BITS-1:0]  latest_ff,   latest_in;
   logic [COUNT_BITS-1:0] count_ff,    count_in;
   logic                  pend_vld_ff, pend_vld_in;
   rsp_type               pend_ff,     pend_in;
   logic                  out_vld_ff,  out_vld_in;
   rsp_type               out_ff,      out_in;
   logic                  select;

   assign select = take && head.valid && (head.start >= latest_ff);

   // a selection is held in a pending register so the final one can be marked
   always_comb begin
      latest_in   = latest_ff;
      count_in    = count_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = 1'b0;
      out_in      = out_ff;
      priority if (run_begin) begin
         latest_in   = '0;
         count_in    = '0;
         pend_vld_in = 1'b0;
      end else if (select) begin
         latest_in                = head.finish;
         count_in                 = count_ff + COUNT_BITS'(1);
         pend_vld_in              = 1'b1;
         pend_in.selection_number = count_ff + COUNT_BITS'(1);
         pend_in.chosen_start     = head.start;
         pend_in.chosen_finish    = head.finish;
         pend_in.last_of_run      = 1'b0;
         out_vld_in               = pend_vld_ff;
         out_in                   = pend_ff;
      end else if (run_end) begin
         pend_vld_in        = 1'b0;
         out_vld_in         = pend_vld_ff;
         out_in             = pend_ff;
         out_in.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff   <= '0;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         latest_ff   <= latest_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

/* design/greedy_activity_selection.sv */
// Greedy activity selection.
// Input: pulse start with req_data while busy is low; the item transfers at
// that clock edge. One activity can be loaded in every cycle while busy
// is low. Each valid activity (finish after start) is placed in a chain
// of 64 sorting cells in the same cycle, ordered by finish time, equal
// finishes in arrival order. Activities beyond 64, and empty intervals,
// are dropped. An item with last_item set ends the set: busy stays high
// until the chain has drained and the flush state has passed. The chain
// shifts one entry a cycle into the greedy filter, which picks every
// activity that starts no earlier than the last picked finish.
// Output: each pick appears on rsp_data for one cycle with rsp_valid high,
// at most one per cycle; the final pick carries last_of_run. There is no
// back-pressure, the receiver must take every transfer. A set with nothing
// stored gives no output.
// Reset (synchronous, active high) empties the chain and returns to idle.
`include "greedy_activity_selection_assert.svh"

module greedy_activity_selection
   import gas_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type     state_ff, state_in;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     cell_entry   [MAX_ACTIVITIES];
   logic          cell_greater [MAX_ACTIVITIES];
   logic          accept;
   logic          run_begin;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign run_begin = accept && req_data.last_item;

   assign new_entry.valid  = 1'b1;
   assign new_entry.start  = req_data.start_time;
   assign new_entry.finish = req_data.finish_time;

   assign ctrl.insert = accept && (req_data.finish_time > req_data.start_time)
                        && !cell_entry[MAX_ACTIVITIES-1].valid;
   assign ctrl.shift  = (state_ff == ST_SCAN) && cell_entry[0].valid;

   for (genvar i = 0; i < MAX_ACTIVITIES; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_greater;

      if (i == 0) begin : g_head
         assign left_entry   = '0;
         assign left_greater = 1'b0;
      end else begin : g_body
         assign left_entry   = cell_entry[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == MAX_ACTIVITIES - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      gas_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_entry    (new_entry),
         .left_entry   (left_entry),
         .left_greater (left_greater),
         .right_entry  (right_entry),
         .entry        (cell_entry[i]),
         .greater      (cell_greater[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_begin) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!cell_entry[0].valid) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   gas_select u_select (
      .clock     (clock),
      .reset     (reset),
      .run_begin (run_begin),
      .take      (ctrl.shift),
      .run_end   (state_ff == ST_FLUSH),
      .head      (cell_entry[0]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `GAS_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_ff), "state not one-hot")
   `GAS_ASSERT_NOW(a_head_sorted, cell_entry[1].valid,
      cell_entry[0].valid && (cell_entry[0].finish <= cell_entry[1].finish),
      "chain head out of order")
   `GAS_ASSERT_NOW(a_chain_empty, state_ff == ST_FLUSH,
      !cell_entry[0].valid && !cell_entry[MAX_ACTIVITIES-1].valid,
      "chain not drained at end of scan")
   `GAS_ASSERT_NEXT(a_no_rsp_idle, state_ff == ST_IDLE && !rsp_valid && !run_begin,
      !rsp_valid, "result transfer outside a run")

endmodule

/* dv/greedy_activity_selection_tb.sv */
`timescale 1ns / 100ps

module greedy_activity_selection_tb;
   import gas_pkg::*;

   typedef struct packed {
      logic [TIME_BITS-1:0] s_time;
      logic [TIME_BITS-1:0] f_time;
   } span_type;

   typedef struct {
      req_type data;
      bit      drain_first;
   } job_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   job_type  job_q[$];
   span_type schedule_q[$];
   rsp_type  picks_q[$];

   int accepted_count = 0;
   int total_items    = 0;
   int error_count    = 0;
   bit drv_go;
   job_type drv_job;
   rsp_type got_pick;
   rsp_type want_pick;

   greedy_activity_selection dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // sorted insert by finish, ties after existing entries; last_item runs the scan
   task automatic absorb_activity(input req_type r);
      int                   pos;
      int                   picks;
      logic [TIME_BITS-1:0] horizon;
      span_type             sp;
      rsp_type              pick;
      rsp_type              run_q[$];
      if (r.finish_time > r.start_time && schedule_q.size() < MAX_ACTIVITIES) begin
         pos = 0;
         while (pos < schedule_q.size() && schedule_q[pos].f_time <= r.finish_time)
            pos++;
         sp.s_time = r.start_time;
         sp.f_time = r.finish_time;
         schedule_q.insert(pos, sp);
      end
      if (r.last_item) begin
         horizon = '0;
         picks = 0;
         foreach (schedule_q[k]) begin
            if (schedule_q[k].s_time >= horizon) begin
               picks++;
               pick.selection_number = COUNT_BITS'(picks);
               pick.chosen_start     = schedule_q[k].s_time;
               pick.chosen_finish    = schedule_q[k].f_time;
               pick.last_of_run      = 1'b0;
               run_q.push_back(pick);
               horizon = schedule_q[k].f_time;
            end
         end
         if (run_q.size() > 0)
            run_q[run_q.size()-1].last_of_run = 1'b1;
         foreach (run_q[k])
            picks_q.push_back(run_q[k]);
         schedule_q.delete();
      end
   endtask

   function automatic int sender_idle_pct();
      if (accepted_count < total_items / 3)
         return 23;
      else if (accepted_count < (2 * total_items) / 3)
         return 83;
      return 0;
   endfunction

   // driver: one nonblocking update of start per edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         drv_go = start;
         if (start && !busy) begin
            absorb_activity(req_data);
            accepted_count++;
            drv_go = 1'b0;
         end
         if (!drv_go && job_q.size() > 0) begin
            if (job_q[0].drain_first && picks_q.size() != 0) begin
               drv_go = 1'b0;
            end else if ($urandom_range(99) < sender_idle_pct()) begin
               drv_go = 1'b0;
            end else begin
               drv_job = job_q.pop_front();
               req_data <= drv_job.data;
               drv_go = 1'b1;
            end
         end
         start <= drv_go;
      end
   end

   // monitor: every strobed transfer must match the oldest pick
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got_pick = rsp_data;
         if (picks_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer sel=%0d start=%0d finish=%0d",
               got_pick.selection_number, got_pick.chosen_start, got_pick.chosen_finish));
         end else begin
            want_pick = picks_q.pop_front();
            if (got_pick.selection_number !== want_pick.selection_number)
               report_mismatch($sformatf("selection_number got %0d want %0d",
                  got_pick.selection_number, want_pick.selection_number));
            if (got_pick.chosen_start !== want_pick.chosen_start)
               report_mismatch($sformatf("chosen_start got %0d want %0d",
                  got_pick.chosen_start, want_pick.chosen_start));
            if (got_pick.chosen_finish !== want_pick.chosen_finish)
               report_mismatch($sformatf("chosen_finish got %0d want %0d",
                  got_pick.chosen_finish, want_pick.chosen_finish));
            if (got_pick.last_of_run !== want_pick.last_of_run)
               report_mismatch($sformatf("last_of_run got %0d want %0d",
                  got_pick.last_of_run, want_pick.last_of_run));
         end
      end
   end

   task automatic queue_activity(input int s, input int f, input bit last, input bit drain);
      job_type j;
      j.data.start_time  = TIME_BITS'(s);
      j.data.finish_time = TIME_BITS'(f);
      j.data.last_item   = last;
      j.drain_first      = drain;
      job_q.push_back(j);
   endtask

   initial begin
      span_type disjoint[MAX_ACTIVITIES];
      span_type tmp;
      int       random_items;
      int       set_size;
      int       s;
      int       f;
      int       j;
      bit       narrow;
      bit       full_done;

      // single widest interval
      queue_activity(0, 65535, 1, 0);
      // only empty intervals: no transfer at all
      queue_activity(100, 100, 0, 0);
      queue_activity(200, 50, 0, 0);
      queue_activity(65535, 0, 1, 0);
      // equal finishes keep arrival order, start equal to last finish is picked,
      // an empty interval still closes the set
      queue_activity(7, 10, 0, 0);
      queue_activity(5, 10, 0, 0);
      queue_activity(10, 20, 0, 0);
      queue_activity(0, 65535, 0, 0);
      queue_activity(65534, 65535, 0, 0);
      queue_activity(20, 20, 1, 0);
      // out-of-order arrival, all chained
      queue_activity(50, 60, 0, 1);
      queue_activity(0, 1, 0, 0);
      queue_activity(30, 40, 0, 0);
      queue_activity(1, 30, 1, 0);
      // heavy overlap
      queue_activity(0, 100, 0, 0);
      queue_activity(10, 20, 0, 0);
      queue_activity(15, 30, 0, 0);
      queue_activity(25, 40, 1, 0);

      random_items = 0;
      full_done = 1'b0;
      while (random_items < 140) begin
         if (!full_done && random_items >= 60) begin
            // full store: 64 disjoint intervals in shuffled order, then dropped extras
            for (int i = 0; i < MAX_ACTIVITIES; i++) begin
               s = i * 1000 + $urandom_range(0, 400);
               disjoint[i].s_time = TIME_BITS'(s);
               disjoint[i].f_time = TIME_BITS'(s + $urandom_range(1, 500));
            end
            for (int i = MAX_ACTIVITIES - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = disjoint[i];
               disjoint[i] = disjoint[j];
               disjoint[j] = tmp;
            end
            for (int i = 0; i < MAX_ACTIVITIES; i++)
               queue_activity(disjoint[i].s_time, disjoint[i].f_time, 0, i == 0);
            queue_activity(0, 1, 0, 0);
            queue_activity(0, 2, 0, 0);
            queue_activity(0, 3, 1, 0);
            random_items += MAX_ACTIVITIES + 3;
            full_done = 1'b1;
         end else if ($urandom_range(99) < 10) begin
            // noise: unconstrained fields, last flag at random
            queue_activity($urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 1), 0);
            random_items++;
         end else begin
            set_size = $urandom_range(1, 12);
            narrow = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < set_size; i++) begin
               if (narrow) begin
                  s = $urandom_range(0, 63);
                  f = s + $urandom_range(1, 20);
               end else begin
                  s = $urandom_range(0, 65534);
                  f = $urandom_range(s + 1, 65535);
               end
               if ($urandom_range(99) < 10)
                  f = s - $urandom_range(0, 3);
               queue_activity(s, f, i == set_size - 1, 0);
            end
            random_items += set_size;
         end
      end
      // close any set left open by noise
      queue_activity($urandom_range(0, 65534), 65535, 1, 0);
      total_items = job_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || picks_q.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #500000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/gas_pkg.sv
design/gas_cell.sv
design/gas_select.sv
design/greedy_activity_selection.sv
dv/greedy_activity_selection_tb.sv
